[rtl/dnsarp_pkg.sv]
// ----------------------------------------------------------------------------
// dnsarp_pkg
// Shared constants and types for the DNS response A-record parser.
// ----------------------------------------------------------------------------
package dnsarp_pkg;

  localparam int unsigned MaxPacketBytes = 512;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 10;
  localparam int unsigned IdW     = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PhaseW  = 4;

  localparam logic [IdW-1:0] ExpectedIdReset = 16'h1234;

  localparam logic [PhaseW-1:0] PhHeader   = 4'd0;
  localparam logic [PhaseW-1:0] PhQname    = 4'd1;
  localparam logic [PhaseW-1:0] PhRecName  = 4'd2;
  localparam logic [PhaseW-1:0] PhRecLabel = 4'd3;
  localparam logic [PhaseW-1:0] PhTypeHi   = 4'd4;
  localparam logic [PhaseW-1:0] PhTypeLo   = 4'd5;
  localparam logic [PhaseW-1:0] PhRdlenHi  = 4'd6;
  localparam logic [PhaseW-1:0] PhRdlenLo  = 4'd7;
  localparam logic [PhaseW-1:0] PhAddr     = 4'd8;

  localparam logic [StatusW-1:0] StatusFound      = 3'd0;
  localparam logic [StatusW-1:0] StatusTooShort   = 3'd1;
  localparam logic [StatusW-1:0] StatusIdMismatch = 3'd2;
  localparam logic [StatusW-1:0] StatusNoAnswers  = 3'd3;
  localparam logic [StatusW-1:0] StatusNoARecord  = 3'd4;

  localparam logic [ByteW-1:0] PointerMask = 8'hC0;
  localparam logic [15:0]      TypeA       = 16'd1;
  localparam logic [15:0]      Ipv4Len     = 16'd4;

  typedef struct packed {
    logic               found;
    logic [AddrW-1:0]   address;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

[rtl/dnsarp_walk.sv]
// ----------------------------------------------------------------------------
// dnsarp_walk
// Per-packet parse state and the combinational step that walks header,
// question and answer records, one byte per step.
// ----------------------------------------------------------------------------
module dnsarp_walk #(
  parameter int unsigned MAX_PACKET_BYTES = dnsarp_pkg::MaxPacketBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [dnsarp_pkg::ByteW-1:0]  data_byte_i,
  input  logic [dnsarp_pkg::LenW-1:0]   packet_length_i,
  input  logic                          last_byte_i,
  input  logic [dnsarp_pkg::IdW-1:0]    expected_id_i,
  output logic                          res_valid_o,
  output dnsarp_pkg::result_t           res_o
);

  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned SW = PW + 17;
  localparam logic [SW-1:0] MaxLen = SW'(MAX_PACKET_BYTES);
  localparam logic [PW-1:0] PosMax = PW'(MAX_PACKET_BYTES);

  logic [PW-1:0]                    pos_q, pos_d;
  logic [PW-1:0]                    nap_q, nap_d;
  logic [dnsarp_pkg::PhaseW-1:0]    phase_q, phase_d;
  logic [15:0]                      ancount_q, ancount_d;
  logic [15:0]                      tried_q, tried_d;
  logic [15:0]                      rtype_q, rtype_d;
  logic [15:0]                      rdlen_q, rdlen_d;
  logic [dnsarp_pkg::AddrW-1:0]     acc_q, acc_d;
  logic                             decided_q, decided_d;

  logic                             dec;
  logic [dnsarp_pkg::StatusW-1:0]   st;
  logic [dnsarp_pkg::AddrW-1:0]     addr;
  logic                             jump, rec, tat, fail;
  logic [SW-1:0]                    jpos, rpos, tpos;
  logic [dnsarp_pkg::PhaseW-1:0]    jph;
  logic [SW-1:0]                    len_ext, p_ext, b_ext;

  always_comb begin
    pos_d     = pos_q;
    nap_d     = nap_q;
    phase_d   = phase_q;
    ancount_d = ancount_q;
    tried_d   = tried_q;
    rtype_d   = rtype_q;
    rdlen_d   = rdlen_q;
    acc_d     = acc_q;
    decided_d = decided_q;
    dec       = 1'b0;
    st        = dnsarp_pkg::StatusNoARecord;
    addr      = '0;
    jump      = 1'b0;
    rec       = 1'b0;
    tat       = 1'b0;
    fail      = 1'b0;
    jpos      = '0;
    rpos      = '0;
    tpos      = '0;
    jph       = dnsarp_pkg::PhQname;
    len_ext   = SW'(packet_length_i);
    if (len_ext > MaxLen) begin
      len_ext = MaxLen;
    end
    p_ext = SW'(pos_q);
    b_ext = SW'(data_byte_i);

    if (step_i) begin
      if (!decided_q) begin
        if (phase_q == dnsarp_pkg::PhHeader) begin
          if (len_ext < SW'(12)) begin
            dec = 1'b1;
            st  = dnsarp_pkg::StatusTooShort;
          end else if (pos_q == PW'(0)) begin
            acc_d = {16'h0000, data_byte_i, 8'h00};
          end else if (pos_q == PW'(1)) begin
            acc_d = {acc_q[31:8], data_byte_i};
            if (acc_d != {16'h0000, expected_id_i}) begin
              dec = 1'b1;
              st  = dnsarp_pkg::StatusIdMismatch;
            end
          end else if (pos_q == PW'(6)) begin
            ancount_d = {data_byte_i, 8'h00};
          end else if (pos_q == PW'(7)) begin
            ancount_d = {ancount_q[15:8], data_byte_i};
            if (ancount_d == 16'h0000) begin
              dec = 1'b1;
              st  = dnsarp_pkg::StatusNoAnswers;
            end
          end else if (pos_q == PW'(11)) begin
            jump = 1'b1;
            jpos = SW'(12);
            jph  = dnsarp_pkg::PhQname;
          end
        end else if (pos_q == nap_q) begin
          unique case (phase_q)
            dnsarp_pkg::PhQname: begin
              if (data_byte_i == '0) begin
                rec  = 1'b1;
                rpos = p_ext + SW'(5);
              end else begin
                jump = 1'b1;
                jpos = p_ext + b_ext + SW'(1);
                jph  = dnsarp_pkg::PhQname;
              end
            end
            dnsarp_pkg::PhRecName: begin
              if ((data_byte_i & dnsarp_pkg::PointerMask) == dnsarp_pkg::PointerMask) begin
                tat  = 1'b1;
                tpos = p_ext + SW'(2);
              end else if (data_byte_i == '0) begin
                tat  = 1'b1;
                tpos = p_ext + SW'(1);
              end else begin
                jump = 1'b1;
                jpos = p_ext + b_ext + SW'(1);
                jph  = dnsarp_pkg::PhRecLabel;
              end
            end
            dnsarp_pkg::PhRecLabel: begin
              if (data_byte_i == '0) begin
                tat  = 1'b1;
                tpos = p_ext + SW'(1);
              end else begin
                jump = 1'b1;
                jpos = p_ext + b_ext + SW'(1);
                jph  = dnsarp_pkg::PhRecLabel;
              end
            end
            dnsarp_pkg::PhTypeHi: begin
              rtype_d = {data_byte_i, 8'h00};
              jump    = 1'b1;
              jpos    = p_ext + SW'(1);
              jph     = dnsarp_pkg::PhTypeLo;
            end
            dnsarp_pkg::PhTypeLo: begin
              rtype_d = {rtype_q[15:8], data_byte_i};
              jump    = 1'b1;
              jpos    = p_ext + SW'(7);
              jph     = dnsarp_pkg::PhRdlenHi;
            end
            dnsarp_pkg::PhRdlenHi: begin
              rdlen_d = {data_byte_i, 8'h00};
              jump    = 1'b1;
              jpos    = p_ext + SW'(1);
              jph     = dnsarp_pkg::PhRdlenLo;
            end
            dnsarp_pkg::PhRdlenLo: begin
              rdlen_d = {rdlen_q[15:8], data_byte_i};
              if (rtype_q == dnsarp_pkg::TypeA && rdlen_d == dnsarp_pkg::Ipv4Len) begin
                if (p_ext + SW'(5) > len_ext) begin
                  fail = 1'b1;
                end else begin
                  acc_d = '0;
                  jump  = 1'b1;
                  jpos  = p_ext + SW'(1);
                  jph   = dnsarp_pkg::PhAddr;
                end
              end else begin
                rec  = 1'b1;
                rpos = p_ext + SW'(1) + SW'(rdlen_d);
              end
            end
            dnsarp_pkg::PhAddr: begin
              acc_d   = {acc_q[23:0], data_byte_i};
              rdlen_d = rdlen_q - 16'd1;
              if (rdlen_d == 16'h0000) begin
                dec  = 1'b1;
                st   = dnsarp_pkg::StatusFound;
                addr = acc_d;
              end else begin
                jump = 1'b1;
                jpos = p_ext + SW'(1);
                jph  = dnsarp_pkg::PhAddr;
              end
            end
            default: begin
              fail = 1'b1;
            end
          endcase
        end

        if (rec) begin
          if (tried_q >= ancount_q || rpos + SW'(12) > len_ext) begin
            fail = 1'b1;
          end else begin
            tried_d = tried_q + 16'd1;
            jump    = 1'b1;
            jpos    = rpos;
            jph     = dnsarp_pkg::PhRecName;
          end
        end
        if (tat) begin
          if (tpos + SW'(10) > len_ext) begin
            fail = 1'b1;
          end else begin
            jump = 1'b1;
            jpos = tpos;
            jph  = dnsarp_pkg::PhTypeHi;
          end
        end
        if (jump) begin
          if (jpos >= len_ext) begin
            fail = 1'b1;
          end else begin
            nap_d   = jpos[PW-1:0];
            phase_d = jph;
          end
        end
        if (fail) begin
          dec  = 1'b1;
          st   = dnsarp_pkg::StatusNoARecord;
          addr = '0;
        end
        if (last_byte_i && !dec) begin
          dec  = 1'b1;
          st   = (p_ext + SW'(1) < SW'(12)) ? dnsarp_pkg::StatusTooShort
                                             : dnsarp_pkg::StatusNoARecord;
          addr = '0;
        end
        if (dec) begin
          decided_d = 1'b1;
        end
      end

      if (pos_q < PosMax) begin
        pos_d = pos_q + PW'(1);
      end
      if (last_byte_i) begin
        pos_d     = '0;
        nap_d     = '0;
        phase_d   = dnsarp_pkg::PhHeader;
        ancount_d = '0;
        tried_d   = '0;
        rtype_d   = '0;
        rdlen_d   = '0;
        acc_d     = '0;
        decided_d = 1'b0;
      end
    end
  end

  assign res_valid_o     = step_i && dec;
  assign res_o.found     = (st == dnsarp_pkg::StatusFound);
  assign res_o.address   = (st == dnsarp_pkg::StatusFound) ? addr : '0;
  assign res_o.status    = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      nap_q     <= '0;
      phase_q   <= dnsarp_pkg::PhHeader;
      ancount_q <= '0;
      tried_q   <= '0;
      rtype_q   <= '0;
      rdlen_q   <= '0;
      acc_q     <= '0;
      decided_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      nap_q     <= nap_d;
      phase_q   <= phase_d;
      ancount_q <= ancount_d;
      tried_q   <= tried_d;
      rtype_q   <= rtype_d;
      rdlen_q   <= rdlen_d;
      acc_q     <= acc_d;
      decided_q <= decided_d;
    end
  end

endmodule

[rtl/dns_response_a_record_parser.sv]
// ----------------------------------------------------------------------------
// dns_response_a_record_parser
// Byte-stream DNS response parser that reports the first IPv4 A record
// address and one status per packet.
// ----------------------------------------------------------------------------
// Path: the byte that decides the packet is held in the input register, and
// its result is then registered in the result register by the walk step.
// Throughput: one byte per cycle unless a held, untaken result stalls the walk.
// Reset: rst_ni clears the packet state and both stream valid flags and
// loads expected_id with 0x1234.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser #(
  parameter int unsigned MAX_PACKET_BYTES = dnsarp_pkg::MaxPacketBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // expected_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [7:0] data_byte, [17:8] packet_length, [23:18] zero
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [31:0] address
  output logic [3:0]  m_axis_tuser     // [0] found, [3:1] status
);

  logic [dnsarp_pkg::IdW-1:0]   expected_id_q;
  logic                         in_valid_q;
  logic [dnsarp_pkg::ByteW-1:0] in_byte_q;
  logic [dnsarp_pkg::LenW-1:0]  in_len_q;
  logic                         in_last_q;
  logic                         out_valid_q;
  dnsarp_pkg::result_t          out_q;
  logic                         advance;
  logic                         res_valid;
  dnsarp_pkg::result_t          res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= dnsarp_pkg::ExpectedIdReset;
    end else if (cfg_we_i) begin
      expected_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_len_q  <= s_axis_tdata[17:8];
      in_last_q <= s_axis_tlast;
    end
  end

  dnsarp_walk #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .data_byte_i    (in_byte_q),
    .packet_length_i(in_len_q),
    .last_byte_i    (in_last_q),
    .expected_id_i  (expected_id_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.address;
  assign m_axis_tuser  = {out_q.status, out_q.found};

endmodule
